FILE: hw/rtl/mqtt_packet_byte_parser_unit_macros.svh
// Assertion macros shared by the parser RTL.
// Used by the queue and back-end modules; no other dependencies.
`ifndef MQTT_PACKET_BYTE_PARSER_UNIT_MACROS_SVH
`define MQTT_PACKET_BYTE_PARSER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Condition must hold at every clock edge out of reset
`define MQTT_ASSERT_ALWAYS(lbl, clk_s, rst_s, expr_s) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (expr_s)) \
	else $error("mqtt assertion failed");
// Antecedent implies consequent in the following clock cycle
`define MQTT_ASSERT_NEXT(lbl, clk_s, rst_s, ante_s, cons_s) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante_s) |=> (cons_s)) \
	else $error("mqtt assertion failed");
`else
`define MQTT_ASSERT_ALWAYS(lbl, clk_s, rst_s, expr_s)
`define MQTT_ASSERT_NEXT(lbl, clk_s, rst_s, ante_s, cons_s)
`endif
`endif

FILE: hw/rtl/mqtt_pkg.sv
// Types, codes and helpers for the MQTT byte parser.
// No dependencies; used by every parser module.
`timescale 1ns / 1ps
package mqtt_pkg;

	// Parser phases
	typedef enum logic [3:0] {
		PH_HEADER  = 4'd0,
		PH_LENGTH  = 4'd1,
		PH_TLEN_HI = 4'd2,
		PH_TLEN_LO = 4'd3,
		PH_TOPIC   = 4'd4,
		PH_MID_HI  = 4'd5,
		PH_MID_LO  = 4'd6,
		PH_PAYLOAD = 4'd7,
		PH_OTHER   = 4'd8
	} phase_t;

	// Packet kinds by control type
	typedef enum logic [1:0] {
		K_IGNORED = 2'd0,
		K_PUBLISH = 2'd1,
		K_ACK     = 2'd2,
		K_PASS    = 2'd3
	} kind_t;

	// Byte classes
	localparam logic [2:0] CLS_HEADER  = 3'd0;
	localparam logic [2:0] CLS_LENGTH  = 3'd1;
	localparam logic [2:0] CLS_TLEN    = 3'd2;
	localparam logic [2:0] CLS_TOPIC   = 3'd3;
	localparam logic [2:0] CLS_MSG_ID  = 3'd4;
	localparam logic [2:0] CLS_PAYLOAD = 3'd5;
	localparam logic [2:0] CLS_OTHER   = 3'd6;

	// Status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_IGNORED   = 3'd1;
	localparam logic [2:0] ST_LEN_LONG  = 3'd2;
	localparam logic [2:0] ST_TOPIC_OVR = 3'd3;
	localparam logic [2:0] ST_SHORT     = 3'd4;

	// Register indexes and reset values
	localparam logic       REG_MAX_LEN_BYTES = 1'b0;
	localparam logic [2:0] MAX_LEN_RESET     = 3'd4;

	// Input word
	typedef struct packed {
		logic [7:0] data_byte;
		logic       resync;
	} rx_word_t;

	// Classified word held in the queue
	typedef struct packed {
		logic [7:0] data_byte;
		logic       resync;
		logic [6:0] low7;
		logic       cont;
		kind_t      hdr_kind;
	} cls_word_t;

	// Result word
	typedef struct packed {
		logic [3:0]  packet_type;
		logic [1:0]  qos_level;
		logic        dup_flag;
		logic        retain_flag;
		logic [2:0]  byte_class;
		logic [7:0]  byte_out;
		logic [27:0] remaining_length;
		logic [15:0] topic_length;
		logic [15:0] message_id;
		logic        packet_end;
		logic [2:0]  status;
	} res_word_t;

	// Map a control packet type to its kind
	function automatic kind_t kind_of(input logic [3:0] ptype);
		kind_t k;
		unique case (ptype)
			4'd3: k = K_PUBLISH;
			4'd4, 4'd5, 4'd6, 4'd7, 4'd11: k = K_ACK;
			4'd2, 4'd9, 4'd12, 4'd13, 4'd14: k = K_PASS;
			default: k = K_IGNORED;
		endcase
		return k;
	endfunction

endpackage

FILE: hw/rtl/mqtt_front.sv
// Front end: accepts stream words and classifies each byte.
// Depends on mqtt_pkg; feeds mqtt_queue.
`timescale 1ns / 1ps
module mqtt_front (
	input  logic                rx_valid,
	output logic                rx_stall,
	input  mqtt_pkg::rx_word_t  rx_word,
	input  logic                q_full,
	output logic                push,
	output mqtt_pkg::cls_word_t push_word
);

	// Stall while the queue has no room
	assign rx_stall = q_full;
	assign push     = rx_valid && !q_full;

	// Classify the byte as length digit and as possible header
	always_comb begin
		push_word.data_byte = rx_word.data_byte;
		push_word.resync    = rx_word.resync;
		push_word.low7      = rx_word.data_byte[6:0];
		push_word.cont      = rx_word.data_byte[7];
		push_word.hdr_kind  = mqtt_pkg::kind_of(rx_word.data_byte[7:4]);
	end

endmodule

FILE: hw/rtl/mqtt_queue.sv
// Short word queue between the front end and the back end.
// Depends on mqtt_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "mqtt_packet_byte_parser_unit_macros.svh"
module mqtt_queue #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  mqtt_pkg::cls_word_t push_word,
	input  logic                pop,
	output mqtt_pkg::cls_word_t pop_word,
	output logic                full,
	output logic                not_empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

	mqtt_pkg::cls_word_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == DEPTH_CNT);
	assign not_empty = (count_q != '0);
	assign pop_word  = mem_q[rd_ptr_q];

	// Store pushed words
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`MQTT_ASSERT_ALWAYS(a_q_no_overflow, clk, arst_n, count_q <= DEPTH_CNT)
	`MQTT_ASSERT_ALWAYS(a_q_pop_nonempty, clk, arst_n, !pop || not_empty)
	`MQTT_ASSERT_ALWAYS(a_q_push_room, clk, arst_n, !push || !full)
	`MQTT_ASSERT_NEXT(a_q_count_up, clk, arst_n, push && !pop, count_q == $past(count_q) + 1'b1)

endmodule

FILE: hw/rtl/mqtt_back.sv
// Back end: packet state machine and result register.
// Depends on mqtt_pkg and the assertion macro header; fed by mqtt_queue.
`timescale 1ns / 1ps
`include "mqtt_packet_byte_parser_unit_macros.svh"
module mqtt_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [2:0]           max_len,
	input  logic                 q_not_empty,
	input  mqtt_pkg::cls_word_t  q_word,
	output logic                 pop,
	output logic                 res_valid,
	input  logic                 res_stall,
	output mqtt_pkg::res_word_t  res_word
);

	mqtt_pkg::phase_t phase_q, phase_n, phase_eff;
	mqtt_pkg::kind_t  kind_q, kind_n;
	logic [7:0]  header_q, header_n;
	logic [27:0] acc_q, acc_n;
	logic [2:0]  cnt_q, cnt_n;
	logic [27:0] bl_q, bl_n;
	logic [15:0] tlen_q, tlen_n;
	logic [15:0] tleft_q, tleft_n;
	logic [15:0] mid_q, mid_n;
	logic        hold_q, hold_n;
	logic [2:0]  code_q, code_n;

	logic        res_valid_q;
	mqtt_pkg::res_word_t res_word_q, res_n;

	logic [27:0] shifted;
	logic [27:0] acc_sum;
	logic [2:0]  cnt_inc;
	logic [2:0]  lim;
	logic [27:0] bl_c;
	logic [15:0] tl_full;
	logic [15:0] tleft_dec;
	logic [27:0] tl_ext;
	logic [27:0] bl_rest;
	logic        qos_nz;
	logic [2:0]  raise_code;
	logic        pkt_end;
	logic [2:0]  cls;
	logic [2:0]  st;

	// Take a word whenever the result register is free or draining
	assign pop       = q_not_empty && (!res_valid_q || !res_stall);
	assign res_valid = res_valid_q;
	assign res_word  = res_word_q;
	assign phase_eff = q_word.resync ? mqtt_pkg::PH_HEADER : phase_q;

	// Length digit weight, running sum and clamped digit limit
	always_comb begin
		unique case (cnt_q[1:0])
			2'd0: shifted = {21'd0, q_word.low7};
			2'd1: shifted = {14'd0, q_word.low7, 7'd0};
			2'd2: shifted = {7'd0, q_word.low7, 14'd0};
			default: shifted = {q_word.low7, 21'd0};
		endcase
		acc_sum = acc_q + shifted;
		cnt_inc = cnt_q + 3'd1;
		if (max_len == 3'd0) begin
			lim = 3'd1;
		end else if (max_len > 3'd4) begin
			lim = 3'd4;
		end else begin
			lim = max_len;
		end
	end

	// Consumed byte count and topic arithmetic
	always_comb begin
		bl_c      = (bl_q != '0) ? bl_q - 28'd1 : '0;
		tl_full   = tlen_q | {8'd0, q_word.data_byte};
		tl_ext    = {12'd0, tl_full};
		bl_rest   = bl_c - tl_ext;
		tleft_dec = (tleft_q != '0) ? tleft_q - 16'd1 : '0;
	end

	// Next state
	always_comb begin
		phase_n    = phase_q;
		kind_n     = kind_q;
		header_n   = header_q;
		acc_n      = acc_q;
		cnt_n      = cnt_q;
		bl_n       = bl_q;
		tlen_n     = tlen_q;
		tleft_n    = tleft_q;
		mid_n      = mid_q;
		hold_n     = hold_q;
		code_n     = code_q;
		raise_code = mqtt_pkg::ST_OK;
		pkt_end    = 1'b0;
		qos_nz     = 1'b0;
		if (q_word.resync) begin
			phase_n = mqtt_pkg::PH_HEADER;
			hold_n  = 1'b0;
			code_n  = mqtt_pkg::ST_OK;
		end
		if (!hold_n) begin
			// Latch a new header and clear packet state
			if (phase_eff == mqtt_pkg::PH_HEADER) begin
				header_n = q_word.data_byte;
				kind_n   = q_word.hdr_kind;
				acc_n    = '0;
				cnt_n    = '0;
				bl_n     = '0;
				tlen_n   = '0;
				tleft_n  = '0;
				mid_n    = '0;
			end
			qos_nz = (header_n[2:1] != 2'd0);
			unique case (phase_eff)
				mqtt_pkg::PH_HEADER: begin
					phase_n = mqtt_pkg::PH_LENGTH;
				end
				mqtt_pkg::PH_LENGTH: begin
					acc_n = acc_sum;
					cnt_n = cnt_inc;
					if (q_word.cont) begin
						if (cnt_inc >= lim) begin
							raise_code = mqtt_pkg::ST_LEN_LONG;
						end
					end else begin
						bl_n = acc_sum;
						if (kind_n == mqtt_pkg::K_PUBLISH || kind_n == mqtt_pkg::K_ACK) begin
							if (acc_sum < 28'd2) begin
								raise_code = mqtt_pkg::ST_SHORT;
							end else if (kind_n == mqtt_pkg::K_PUBLISH) begin
								phase_n = mqtt_pkg::PH_TLEN_HI;
							end else begin
								phase_n = mqtt_pkg::PH_MID_HI;
							end
						end else if (acc_sum == '0) begin
							pkt_end = 1'b1;
							phase_n = mqtt_pkg::PH_HEADER;
						end else begin
							phase_n = mqtt_pkg::PH_OTHER;
						end
					end
				end
				mqtt_pkg::PH_TLEN_HI: begin
					bl_n    = bl_c;
					tlen_n  = {q_word.data_byte, 8'd0};
					phase_n = mqtt_pkg::PH_TLEN_LO;
				end
				mqtt_pkg::PH_TLEN_LO: begin
					bl_n    = bl_c;
					tlen_n  = tl_full;
					tleft_n = tl_full;
					priority if (tl_ext > bl_c) begin
						raise_code = mqtt_pkg::ST_TOPIC_OVR;
					end else if (qos_nz && bl_rest < 28'd2) begin
						raise_code = mqtt_pkg::ST_SHORT;
					end else if (tl_full == '0) begin
						if (bl_c == '0) begin
							pkt_end = 1'b1;
							phase_n = mqtt_pkg::PH_HEADER;
						end else begin
							phase_n = qos_nz ? mqtt_pkg::PH_MID_HI : mqtt_pkg::PH_PAYLOAD;
						end
					end else begin
						phase_n = mqtt_pkg::PH_TOPIC;
					end
				end
				mqtt_pkg::PH_TOPIC: begin
					bl_n    = bl_c;
					tleft_n = tleft_dec;
					if (tleft_dec == '0) begin
						if (bl_c == '0) begin
							pkt_end = 1'b1;
							phase_n = mqtt_pkg::PH_HEADER;
						end else begin
							phase_n = qos_nz ? mqtt_pkg::PH_MID_HI : mqtt_pkg::PH_PAYLOAD;
						end
					end
				end
				mqtt_pkg::PH_MID_HI: begin
					bl_n  = bl_c;
					mid_n = {q_word.data_byte, 8'd0};
					if (bl_c == '0) begin
						pkt_end = 1'b1;
						phase_n = mqtt_pkg::PH_HEADER;
					end else begin
						phase_n = mqtt_pkg::PH_MID_LO;
					end
				end
				mqtt_pkg::PH_MID_LO: begin
					bl_n  = bl_c;
					mid_n = mid_q | {8'd0, q_word.data_byte};
					if (bl_c == '0) begin
						pkt_end = 1'b1;
						phase_n = mqtt_pkg::PH_HEADER;
					end else if (kind_n == mqtt_pkg::K_PUBLISH) begin
						phase_n = mqtt_pkg::PH_PAYLOAD;
					end else begin
						phase_n = mqtt_pkg::PH_OTHER;
					end
				end
				default: begin
					bl_n = bl_c;
					if (bl_c == '0) begin
						pkt_end = 1'b1;
						phase_n = mqtt_pkg::PH_HEADER;
					end
				end
			endcase
			// Enter error hold
			if (raise_code != mqtt_pkg::ST_OK) begin
				hold_n  = 1'b1;
				code_n  = raise_code;
				phase_n = mqtt_pkg::PH_HEADER;
			end
		end
	end

	// Outputs: class, status and the result word
	always_comb begin
		if (hold_q && !q_word.resync) begin
			cls = mqtt_pkg::CLS_OTHER;
			st  = code_q;
		end else begin
			unique case (phase_eff)
				mqtt_pkg::PH_HEADER:  cls = mqtt_pkg::CLS_HEADER;
				mqtt_pkg::PH_LENGTH:  cls = mqtt_pkg::CLS_LENGTH;
				mqtt_pkg::PH_TLEN_HI: cls = mqtt_pkg::CLS_TLEN;
				mqtt_pkg::PH_TLEN_LO: cls = mqtt_pkg::CLS_TLEN;
				mqtt_pkg::PH_TOPIC:   cls = mqtt_pkg::CLS_TOPIC;
				mqtt_pkg::PH_MID_HI:  cls = mqtt_pkg::CLS_MSG_ID;
				mqtt_pkg::PH_MID_LO:  cls = mqtt_pkg::CLS_MSG_ID;
				mqtt_pkg::PH_PAYLOAD: cls = mqtt_pkg::CLS_PAYLOAD;
				default:              cls = mqtt_pkg::CLS_OTHER;
			endcase
			if (raise_code != mqtt_pkg::ST_OK) begin
				st = raise_code;
			end else if (kind_n == mqtt_pkg::K_IGNORED) begin
				st = mqtt_pkg::ST_IGNORED;
			end else begin
				st = mqtt_pkg::ST_OK;
			end
		end
		res_n.packet_type      = header_n[7:4];
		res_n.qos_level        = header_n[2:1];
		res_n.dup_flag         = header_n[3];
		res_n.retain_flag      = header_n[0];
		res_n.byte_class       = cls;
		res_n.byte_out         = q_word.data_byte;
		res_n.remaining_length = acc_n;
		res_n.topic_length     = tlen_n;
		res_n.message_id       = mid_n;
		res_n.packet_end       = pkt_end;
		res_n.status           = st;
	end

	// Hold parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= mqtt_pkg::PH_HEADER;
			kind_q      <= mqtt_pkg::K_IGNORED;
			header_q    <= '0;
			acc_q       <= '0;
			cnt_q       <= '0;
			bl_q        <= '0;
			tlen_q      <= '0;
			tleft_q     <= '0;
			mid_q       <= '0;
			hold_q      <= 1'b0;
			code_q      <= mqtt_pkg::ST_OK;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q     <= phase_n;
				kind_q      <= kind_n;
				header_q    <= header_n;
				acc_q       <= acc_n;
				cnt_q       <= cnt_n;
				bl_q        <= bl_n;
				tlen_q      <= tlen_n;
				tleft_q     <= tleft_n;
				mid_q       <= mid_n;
				hold_q      <= hold_n;
				code_q      <= code_n;
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (pop) begin
			res_word_q <= res_n;
		end
	end

	`MQTT_ASSERT_ALWAYS(a_b_hold_at_header, clk, arst_n, !hold_q || phase_q == mqtt_pkg::PH_HEADER)
	`MQTT_ASSERT_ALWAYS(a_b_hold_code, clk, arst_n, hold_q == (code_q != mqtt_pkg::ST_OK))
	`MQTT_ASSERT_NEXT(a_b_resync_header, clk, arst_n, pop && q_word.resync, res_word_q.byte_class == mqtt_pkg::CLS_HEADER)
	`MQTT_ASSERT_ALWAYS(a_b_end_no_error, clk, arst_n, !(res_valid_q && res_word_q.packet_end) || res_word_q.status == mqtt_pkg::ST_OK || res_word_q.status == mqtt_pkg::ST_IGNORED)

endmodule

FILE: hw/rtl/mqtt_packet_byte_parser_unit.sv
// MQTT byte parser: an accepted byte is written to the queue, then its result is loaded
// into the result register, where it is valid. Throughput one byte per cycle while the
// result output is not stalled, set by the packet state update in the back end.
// Reset clears the queue, the parser state (awaiting header, no error hold) and
// sets max_length_bytes to 4.
// Top level: instantiates mqtt_front, mqtt_queue and mqtt_back; uses mqtt_pkg.
`timescale 1ns / 1ps
module mqtt_packet_byte_parser_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rx_valid,
	output logic                rx_stall,
	input  mqtt_pkg::rx_word_t  rx_word,
	output logic                res_valid,
	input  logic                res_stall,
	output mqtt_pkg::res_word_t res_word,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	logic                q_push;
	mqtt_pkg::cls_word_t q_push_word;
	logic                q_pop;
	mqtt_pkg::cls_word_t q_pop_word;
	logic                q_full;
	logic                q_not_empty;
	logic [2:0]          max_len_q;
	logic                cfg_hit;

	// Register file: one register, selected by paddr[2] low (addresses 0 to 3)
	assign pready  = 1'b1;
	assign cfg_hit = (paddr[2] == mqtt_pkg::REG_MAX_LEN_BYTES);
	assign prdata  = cfg_hit ? {29'd0, max_len_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= mqtt_pkg::MAX_LEN_RESET;
		end else if (psel && penable && pwrite && pready && cfg_hit) begin
			max_len_q <= pwdata[2:0];
		end
	end

	mqtt_front u_front (
		.rx_valid  (rx_valid),
		.rx_stall  (rx_stall),
		.rx_word   (rx_word),
		.q_full    (q_full),
		.push      (q_push),
		.push_word (q_push_word)
	);

	mqtt_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_word (q_push_word),
		.pop       (q_pop),
		.pop_word  (q_pop_word),
		.full      (q_full),
		.not_empty (q_not_empty)
	);

	mqtt_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.max_len     (max_len_q),
		.q_not_empty (q_not_empty),
		.q_word      (q_pop_word),
		.pop         (q_pop),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res_word    (res_word)
	);

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for the MQTT byte parser unit: a directed table, then random packets.
// Holds its own model of the parser state; needs mqtt_pkg and mqtt_packet_byte_parser_unit.
`timescale 1ns / 1ps
module tb_top;
	import mqtt_pkg::*;

	// Control packet types used by the model and the directed table
	localparam logic [3:0] PT_CONNACK     = 4'd2;
	localparam logic [3:0] PT_PUBLISH     = 4'd3;
	localparam logic [3:0] PT_PUBACK      = 4'd4;
	localparam logic [3:0] PT_PUBREC      = 4'd5;
	localparam logic [3:0] PT_PUBREL      = 4'd6;
	localparam logic [3:0] PT_PUBCOMP     = 4'd7;
	localparam logic [3:0] PT_SUBACK      = 4'd9;
	localparam logic [3:0] PT_UNSUBACK    = 4'd11;
	localparam logic [3:0] PT_PINGREQ     = 4'd12;
	localparam logic [3:0] PT_PINGRESP    = 4'd13;
	localparam logic [3:0] PT_DISCONNECT  = 4'd14;
	localparam logic [3:0] PT_RESERVED_HI = 4'd15;

	localparam int MAX_REPORTS  = 40;
	localparam int HOLD_CYCLES  = 300;
	localparam int PHASE_WORDS  = 150;
	localparam int NUM_PHASES   = 8;

	typedef struct {
		rx_word_t  w;
		bit        fixed;
		res_word_t want;
	} stim_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        rx_valid = 1'b0;
	logic        rx_stall;
	rx_word_t    rx_word = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	res_word_t   res_word;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// Typed-in expectation that travels with the word on the input channel
	bit          tx_fixed = 1'b0;
	res_word_t   tx_want = '0;

	stim_t       tx_q [$];
	res_word_t   parsed_q [$];
	stim_t       directed_tbl [29];
	int          fail_count = 0;
	int          send_idle_pct = 0;
	int          stall_pct = 0;
	bit          hold_armed = 1'b0;
	bit          hold_taken = 1'b0;
	res_word_t   want_res;
	res_word_t   pred_res;

	// Parser model state
	phase_t      prs_phase;
	logic [7:0]  prs_header;
	logic [27:0] prs_len;
	logic [2:0]  prs_len_cnt;
	logic [27:0] prs_left;
	logic [15:0] prs_topic_len;
	logic [15:0] prs_topic_left;
	logic [15:0] prs_msg_id;
	bit          prs_held;
	logic [2:0]  prs_held_code;
	logic [2:0]  max_len_cfg;

	mqtt_packet_byte_parser_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_valid  (rx_valid),
		.rx_stall  (rx_stall),
		.rx_word   (rx_word),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_word  (res_word),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic kind_t kind_for_type(input logic [3:0] t);
		case (t)
			PT_PUBLISH: return K_PUBLISH;
			PT_PUBACK, PT_PUBREC, PT_PUBREL, PT_PUBCOMP, PT_UNSUBACK: return K_ACK;
			PT_CONNACK, PT_SUBACK, PT_PINGREQ, PT_PINGRESP, PT_DISCONNECT: return K_PASS;
			default: return K_IGNORED;
		endcase
	endfunction

	function automatic logic [2:0] enter_error_hold(input logic [2:0] code);
		prs_held = 1'b1;
		prs_held_code = code;
		prs_phase = PH_HEADER;
		return code;
	endfunction

	function automatic void take_body_byte();
		if (prs_left != 28'd0)
			prs_left = prs_left - 28'd1;
	endfunction

	// Pick the phase after the topic; true when the packet ends here
	function automatic logic topic_done(input logic [1:0] q);
		if (prs_left == 28'd0) begin
			prs_phase = PH_HEADER;
			return 1'b1;
		end
		prs_phase = (q != 2'd0) ? PH_MID_HI : PH_PAYLOAD;
		return 1'b0;
	endfunction

	function automatic res_word_t parsed_word(input logic [3:0] pt, input logic [1:0] q,
			input logic d, input logic r, input logic [2:0] cls, input logic [7:0] b,
			input logic [27:0] rl, input logic [15:0] tl, input logic [15:0] mid,
			input logic e, input logic [2:0] st);
		res_word_t x;
		x.packet_type = pt;
		x.qos_level = q;
		x.dup_flag = d;
		x.retain_flag = r;
		x.byte_class = cls;
		x.byte_out = b;
		x.remaining_length = rl;
		x.topic_length = tl;
		x.message_id = mid;
		x.packet_end = e;
		x.status = st;
		return x;
	endfunction

	// Advance the parser model by one stream word and return its result word
	function automatic res_word_t parse_stream_byte(input rx_word_t w);
		kind_t      k;
		logic [1:0] q;
		logic [2:0] lim;
		logic [2:0] cls;
		logic [2:0] st;
		logic       last;
		cls = CLS_OTHER;
		st = ST_OK;
		last = 1'b0;
		if (w.resync) begin
			prs_phase = PH_HEADER;
			prs_held = 1'b0;
			prs_held_code = ST_OK;
		end
		if (prs_held) begin
			st = prs_held_code;
		end else begin
			if (prs_phase == PH_HEADER) begin
				prs_header = w.data_byte;
				prs_len = '0;
				prs_len_cnt = '0;
				prs_left = '0;
				prs_topic_len = '0;
				prs_topic_left = '0;
				prs_msg_id = '0;
			end
			k = kind_for_type(prs_header[7:4]);
			q = prs_header[2:1];
			case (prs_phase)
				PH_HEADER: begin
					cls = CLS_HEADER;
					prs_phase = PH_LENGTH;
				end
				PH_LENGTH: begin
					lim = (max_len_cfg == 3'd0) ? 3'd1 :
						(max_len_cfg > 3'd4) ? 3'd4 : max_len_cfg;
					cls = CLS_LENGTH;
					prs_len = prs_len + (28'(w.data_byte[6:0]) << (7 * prs_len_cnt[1:0]));
					prs_len_cnt = prs_len_cnt + 3'd1;
					if (w.data_byte[7]) begin
						if (prs_len_cnt >= lim)
							st = enter_error_hold(ST_LEN_LONG);
					end else begin
						prs_left = prs_len;
						if (k == K_PUBLISH || k == K_ACK) begin
							if (prs_left < 28'd2)
								st = enter_error_hold(ST_SHORT);
							else
								prs_phase = (k == K_PUBLISH) ? PH_TLEN_HI : PH_MID_HI;
						end else if (prs_left == 28'd0) begin
							last = 1'b1;
							prs_phase = PH_HEADER;
						end else begin
							prs_phase = PH_OTHER;
						end
					end
				end
				PH_TLEN_HI: begin
					cls = CLS_TLEN;
					take_body_byte();
					prs_topic_len = {w.data_byte, 8'h00};
					prs_phase = PH_TLEN_LO;
				end
				PH_TLEN_LO: begin
					cls = CLS_TLEN;
					take_body_byte();
					prs_topic_len = {prs_topic_len[15:8], w.data_byte};
					prs_topic_left = prs_topic_len;
					if (28'(prs_topic_len) > prs_left)
						st = enter_error_hold(ST_TOPIC_OVR);
					else if (q != 2'd0 && prs_left - 28'(prs_topic_len) < 28'd2)
						st = enter_error_hold(ST_SHORT);
					else if (prs_topic_len == 16'd0)
						last = topic_done(q);
					else
						prs_phase = PH_TOPIC;
				end
				PH_TOPIC: begin
					cls = CLS_TOPIC;
					take_body_byte();
					if (prs_topic_left != 16'd0)
						prs_topic_left = prs_topic_left - 16'd1;
					if (prs_topic_left == 16'd0)
						last = topic_done(q);
				end
				PH_MID_HI: begin
					cls = CLS_MSG_ID;
					take_body_byte();
					prs_msg_id = {w.data_byte, 8'h00};
					if (prs_left == 28'd0) begin
						last = 1'b1;
						prs_phase = PH_HEADER;
					end else begin
						prs_phase = PH_MID_LO;
					end
				end
				PH_MID_LO: begin
					cls = CLS_MSG_ID;
					take_body_byte();
					prs_msg_id = {prs_msg_id[15:8], w.data_byte};
					if (prs_left == 28'd0) begin
						last = 1'b1;
						prs_phase = PH_HEADER;
					end else begin
						prs_phase = (k == K_PUBLISH) ? PH_PAYLOAD : PH_OTHER;
					end
				end
				default: begin
					cls = (prs_phase == PH_PAYLOAD) ? CLS_PAYLOAD : CLS_OTHER;
					take_body_byte();
					if (prs_left == 28'd0) begin
						last = 1'b1;
						prs_phase = PH_HEADER;
					end
				end
			endcase
			if (k == K_IGNORED && st == ST_OK)
				st = ST_IGNORED;
		end
		return parsed_word(prs_header[7:4], prs_header[2:1], prs_header[3], prs_header[0],
			cls, w.data_byte, prs_len, prs_topic_len, prs_msg_id, last, st);
	endfunction

	function automatic stim_t stream_row(input logic [7:0] b, input logic rs);
		stim_t s;
		s.w.data_byte = b;
		s.w.resync = rs;
		s.fixed = 1'b0;
		s.want = '0;
		return s;
	endfunction

	function automatic stim_t known_row(input logic [7:0] b, input logic rs, input res_word_t r);
		stim_t s;
		s = stream_row(b, rs);
		s.fixed = 1'b1;
		s.want = r;
		return s;
	endfunction

	task automatic add_word(input logic [7:0] b, input logic rs);
		tx_q.push_back(stream_row(b, rs));
	endtask

	// Queue one packet: mostly well formed, sometimes short, overrunning or cut off
	task automatic queue_random_packet();
		kind_t      want_kind;
		logic [3:0] t;
		logic [7:0] hdr_b;
		logic [15:0] tl_v;
		logic [6:0] grp;
		int         pick, body_len, min_len, extra, n_len, m_len, i, cut;
		bit         overrun;
		logic [7:0] body [$];
		pick = $urandom_range(99);
		want_kind = (pick < 40) ? K_PUBLISH : (pick < 65) ? K_ACK :
			(pick < 85) ? K_PASS : K_IGNORED;
		do t = 4'($urandom); while (kind_for_type(t) != want_kind);
		hdr_b = {t, 4'($urandom)};
		extra = ($urandom_range(49) == 0) ? $urandom_range(128, 160) : $urandom_range(0, 8);
		overrun = 1'b0;
		case (want_kind)
			K_PUBLISH: begin
				min_len = (hdr_b[2:1] != 2'd0) ? 4 : 2;
				if ($urandom_range(9) == 0) begin
					overrun = 1'b1;
					tl_v = 16'($urandom);
				end else begin
					tl_v = 16'($urandom_range(0, extra));
				end
				body.push_back(tl_v[15:8]);
				body.push_back(tl_v[7:0]);
				if (!overrun) begin
					repeat (tl_v) body.push_back(8'($urandom));
					if (hdr_b[2:1] != 2'd0) begin
						body.push_back(8'($urandom));
						body.push_back(8'($urandom));
					end
				end
			end
			K_ACK: begin
				min_len = 2;
				body.push_back(8'($urandom));
				body.push_back(8'($urandom));
			end
			default: min_len = 0;
		endcase
		body_len = min_len + extra;
		if ($urandom_range(9) == 0)
			body_len = $urandom_range(0, min_len);
		while (body.size() < body_len) body.push_back(8'($urandom));
		while (body.size() > body_len) void'(body.pop_back());

		add_word(hdr_b, $urandom_range(7) != 0);
		if ($urandom_range(29) == 0) begin
			// largest length field, body cut short
			add_word(8'hFF, 1'b0);
			add_word(8'hFF, 1'b0);
			add_word(8'hFF, 1'b0);
			add_word(8'h7F, 1'b0);
			cut = $urandom_range(0, 8);
		end else begin
			m_len = (body_len < 128) ? 1 : 2;
			n_len = ($urandom_range(3) == 0) ? $urandom_range(m_len, 5) : m_len;
			for (i = 0; i < n_len; i++) begin
				grp = (i < 4) ? 7'(body_len >> (7 * i)) : 7'd0;
				add_word({i < n_len - 1, grp}, 1'b0);
			end
			cut = ($urandom_range(11) == 0) ? $urandom_range(0, body.size()) : body.size();
		end
		while (body.size() > cut) void'(body.pop_back());
		foreach (body[i])
			add_word(body[i], $urandom_range(49) == 0);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Offer every queued word, idling between words at the phase's rate
	task automatic send_words();
		stim_t s;
		while (tx_q.size() != 0) begin
			s = tx_q.pop_front();
			if ($urandom_range(99) < send_idle_pct) begin
				rx_valid <= 1'b0;
				@(posedge clk);
				while ($urandom_range(99) < send_idle_pct) @(posedge clk);
			end
			rx_valid <= 1'b1;
			rx_word <= s.w;
			tx_fixed <= s.fixed;
			tx_want <= s.want;
			@(posedge clk);
			while (rx_stall) @(posedge clk);
		end
		rx_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		@(posedge clk);
		while (parsed_q.size() != 0) @(posedge clk);
	endtask

	task automatic compare_field(input string fname, input logic [27:0] want,
			input logic [27:0] got);
		if (want !== got) begin
			fail_count++;
			if (fail_count <= MAX_REPORTS)
				$display("%0t ns: %s expected %0h got %0h", $time, fname, want, got);
		end
	endtask

	// Check result words against the oldest expectation; predict each accepted word
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (parsed_q.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("%0t ns: result word %h expected none", $time, res_word);
				end else begin
					want_res = parsed_q.pop_front();
					compare_field("packet_type", want_res.packet_type, res_word.packet_type);
					compare_field("qos_level", want_res.qos_level, res_word.qos_level);
					compare_field("dup_flag", want_res.dup_flag, res_word.dup_flag);
					compare_field("retain_flag", want_res.retain_flag, res_word.retain_flag);
					compare_field("byte_class", want_res.byte_class, res_word.byte_class);
					compare_field("byte_out", want_res.byte_out, res_word.byte_out);
					compare_field("remaining_length", want_res.remaining_length,
						res_word.remaining_length);
					compare_field("topic_length", want_res.topic_length, res_word.topic_length);
					compare_field("message_id", want_res.message_id, res_word.message_id);
					compare_field("packet_end", want_res.packet_end, res_word.packet_end);
					compare_field("status", want_res.status, res_word.status);
				end
			end
			if (rx_valid && !rx_stall) begin
				pred_res = parse_stream_byte(rx_word);
				parsed_q.push_back(tx_fixed ? tx_want : pred_res);
			end
		end
	end

	// Drive the result stall: random, plus one long hold when armed
	initial begin : result_stall_drv
		int n;
		forever begin
			@(posedge clk);
			if (hold_armed && !hold_taken) begin
				hold_taken = 1'b1;
				for (n = 0; n < HOLD_CYCLES; n++) begin
					res_stall <= 1'b1;
					@(posedge clk);
				end
			end
			res_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	initial begin : run_limit
		#2_000_000;
		$display("timeout waiting for the parser");
		$display("simulation failed");
		$finish;
	end

	initial begin : main_seq
		logic [2:0] cfg_plan [NUM_PHASES];
		int         send_plan [NUM_PHASES];
		int         stall_plan [NUM_PHASES];
		logic [31:0] wr_val;
		int         p;
		cfg_plan = '{3'd4, 3'd1, 3'd2, 3'd3, 3'd0, 3'd5, 3'd7, 3'd4};
		send_plan = '{0, 53, 0, 25, 0, 53, 0, 25};
		stall_plan = '{0, 0, 53, 25, 0, 0, 53, 25};

		prs_phase = PH_HEADER;
		prs_header = '0;
		prs_len = '0;
		prs_len_cnt = '0;
		prs_left = '0;
		prs_topic_len = '0;
		prs_topic_left = '0;
		prs_msg_id = '0;
		prs_held = 1'b0;
		prs_held_code = ST_OK;
		max_len_cfg = MAX_LEN_RESET;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words: good PUBLISH, ignored type with a too-long length, error hold,
		// short ack, missing message id, topic overrun, empty body, extra ack bytes
		directed_tbl = '{
			known_row(8'h30, 1'b1, parsed_word(PT_PUBLISH, 2'd0, 1'b0, 1'b0, CLS_HEADER,
				8'h30, 28'd0, 16'd0, 16'd0, 1'b0, ST_OK)),
			known_row(8'h04, 1'b0, parsed_word(PT_PUBLISH, 2'd0, 1'b0, 1'b0, CLS_LENGTH,
				8'h04, 28'd4, 16'd0, 16'd0, 1'b0, ST_OK)),
			stream_row(8'h00, 1'b0),
			stream_row(8'h01, 1'b0),
			stream_row(8'h61, 1'b0),
			stream_row(8'hFF, 1'b0),
			known_row(8'hFF, 1'b1, parsed_word(PT_RESERVED_HI, 2'd3, 1'b1, 1'b1, CLS_HEADER,
				8'hFF, 28'd0, 16'd0, 16'd0, 1'b0, ST_IGNORED)),
			stream_row(8'hFF, 1'b0),
			stream_row(8'hFF, 1'b0),
			stream_row(8'hFF, 1'b0),
			known_row(8'hFF, 1'b0, parsed_word(PT_RESERVED_HI, 2'd3, 1'b1, 1'b1, CLS_LENGTH,
				8'hFF, 28'hFFFFFFF, 16'd0, 16'd0, 1'b0, ST_LEN_LONG)),
			known_row(8'h00, 1'b0, parsed_word(PT_RESERVED_HI, 2'd3, 1'b1, 1'b1, CLS_OTHER,
				8'h00, 28'hFFFFFFF, 16'd0, 16'd0, 1'b0, ST_LEN_LONG)),
			stream_row(8'h40, 1'b1),
			known_row(8'h01, 1'b0, parsed_word(PT_PUBACK, 2'd0, 1'b0, 1'b0, CLS_LENGTH,
				8'h01, 28'd1, 16'd0, 16'd0, 1'b0, ST_SHORT)),
			stream_row(8'h3F, 1'b1),
			stream_row(8'h03, 1'b0),
			stream_row(8'h00, 1'b0),
			stream_row(8'h00, 1'b0),
			stream_row(8'h32, 1'b1),
			stream_row(8'h02, 1'b0),
			stream_row(8'h00, 1'b0),
			known_row(8'h05, 1'b0, parsed_word(PT_PUBLISH, 2'd1, 1'b0, 1'b0, CLS_TLEN,
				8'h05, 28'd2, 16'd5, 16'd0, 1'b0, ST_TOPIC_OVR)),
			stream_row(8'hC0, 1'b1),
			known_row(8'h00, 1'b0, parsed_word(PT_PINGREQ, 2'd0, 1'b0, 1'b0, CLS_LENGTH,
				8'h00, 28'd0, 16'd0, 16'd0, 1'b1, ST_OK)),
			stream_row(8'hB0, 1'b1),
			stream_row(8'h03, 1'b0),
			stream_row(8'h12, 1'b0),
			stream_row(8'h34, 1'b0),
			stream_row(8'h99, 1'b0)
		};
		foreach (directed_tbl[i])
			tx_q.push_back(directed_tbl[i]);
		send_words();
		wait_drained();

		// Random phases: one limit setting and one idle pattern each
		for (p = 0; p < NUM_PHASES; p++) begin
			wr_val = ($urandom & 32'hFFFF_FFF8) | 32'(cfg_plan[p]);
			apb_write({REG_MAX_LEN_BYTES, 2'b00}, wr_val);
			max_len_cfg = wr_val[2:0];
			send_idle_pct = send_plan[p];
			stall_pct = stall_plan[p];
			if (p == 4)
				hold_armed = 1'b1;
			while (tx_q.size() < PHASE_WORDS) begin
				if ($urandom_range(9) == 0)
					add_word(8'($urandom), 1'($urandom));
				else
					queue_random_packet();
			end
			send_words();
			wait_drained();
		end

		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
